@@ hdl/cbor42_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbor42_pkg
// Types and constants for the tag-42 link parser: parse phases, status codes
// and the CBOR byte values that the header check compares against.
// ----------------------------------------------------------------------------
package cbor42_pkg;

    localparam int unsigned COUNT_W = 8;

    localparam logic [7:0] TAG0_BYTE       = 8'hD8;
    localparam logic [7:0] TAG1_BYTE       = 8'h2A;
    localparam logic [7:0] MAJOR_MASK      = 8'hE0;
    localparam logic [7:0] MAJOR_BSTR      = 8'h40;
    localparam logic [7:0] INFO_MASK       = 8'h1F;
    localparam logic [7:0] INFO_LEN8       = 8'd24;
    localparam logic [7:0] PREFIX_IDENTITY = 8'h00;
    localparam logic [7:0] CID_LEN_MAX     = 8'd100;
    localparam logic [7:0] CAPACITY_RESET  = 8'd100;
    localparam logic [7:0] MIN_LINK_BYTES  = 8'd4;

    typedef enum logic [7:0] {
        PH_TAG0   = 8'b0000_0001,
        PH_TAG1   = 8'b0000_0010,
        PH_HDR    = 8'b0000_0100,
        PH_LEN    = 8'b0000_1000,
        PH_PREFIX = 8'b0001_0000,
        PH_CID    = 8'b0010_0000,
        PH_TRAIL  = 8'b0100_0000,
        PH_ERR    = 8'b1000_0000
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_TAG0      = 4'd2,
        ST_TAG1      = 4'd3,
        ST_NOT_BSTR  = 4'd4,
        ST_LEN_FORM  = 4'd5,
        ST_TRUNCATED = 4'd6,
        ST_PREFIX    = 4'd7,
        ST_CID_LEN   = 4'd8,
        ST_CAPACITY  = 4'd9
    } status_t;

    typedef struct packed {
        logic       cid_byte_valid;
        logic [7:0] cid_byte;
        logic       done_res;
        status_t    status;
        logic [6:0] cid_length;
    } result_t;

endpackage : cbor42_pkg
`default_nettype wire

@@ hdl/cbor_tag42_link_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbor_tag42_link_parser_core
// Streaming decoder for a tag-42 CID link: checks tag, byte-string header and
// multibase prefix, forwards CID bytes and reports status on the last byte.
// ----------------------------------------------------------------------------
//  channel | signals                                    | role
//  --------+--------------------------------------------+-----------------------
//  in      | in_valid, in_ready, link_byte, is_last     | one link byte/transfer
//  out     | out_valid, out_ready, cid_byte_valid,      | CID byte and/or final
//          | cid_byte, done_res, status, cid_length     | status per transfer
//  cfg     | cfg_valid, cfg_ready, cfg_data             | cid_capacity write
//
//  One byte per cycle while in_ready is high. Taking a byte updates the parse
//  state and registers its result in the head entry, or the skid while held.
//  A two-entry output queue (head plus skid) keeps in_ready independent of
//  out_ready; in_ready drops only while the skid entry is occupied.
//  Reset clears the parse state and sets cid_capacity to 100; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module cbor_tag42_link_parser_core #(
    parameter int unsigned MAX_LINK_BYTES = 255
) (
    input  wire                   clk,
    input  wire                   rst_n,
    // input bytes
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [7:0]            link_byte,
    input  wire                   is_last,
    // results
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic                  cid_byte_valid,
    output logic [7:0]            cid_byte,
    output logic                  done_res,
    output cbor42_pkg::status_t   status,
    output logic [6:0]            cid_length,
    // configuration
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [7:0]            cfg_data
);
    import cbor42_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LINK_BYTES);

    logic [7:0]         capacity_reg;
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         pay_len_reg, pay_len_next;
    logic [7:0]         pay_seen_reg, pay_seen_next;
    status_t            err_reg, err_next;

    logic               head_valid_reg, skid_valid_reg;
    result_t            head_reg, skid_reg;

    logic               in_xfer, out_xfer, push, emit;
    logic [7:0]         info, cid_len;
    status_t            fin_status;
    result_t            res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = head_valid_reg;
    assign out_xfer  = head_valid_reg && out_ready;

    assign cid_byte_valid = head_reg.cid_byte_valid;
    assign cid_byte       = head_reg.cid_byte;
    assign done_res       = head_reg.done_res;
    assign status         = head_reg.status;
    assign cid_length     = head_reg.cid_length;

    assign info = link_byte & INFO_MASK;

    // advance the parse state by one byte, until MAX_COUNT bytes are counted
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        pay_len_next  = pay_len_reg;
        pay_seen_next = pay_seen_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        if (count_reg < MAX_COUNT)
        begin
            count_next = count_reg + 1'b1;
            unique case (phase_reg)
                PH_TAG0:
                begin
                    if (link_byte != TAG0_BYTE)
                    begin
                        err_next   = ST_TAG0;
                        phase_next = PH_ERR;
                    end
                    else
                        phase_next = PH_TAG1;
                end
                PH_TAG1:
                begin
                    if (link_byte != TAG1_BYTE)
                    begin
                        err_next   = ST_TAG1;
                        phase_next = PH_ERR;
                    end
                    else
                        phase_next = PH_HDR;
                end
                PH_HDR:
                begin
                    priority if ((link_byte & MAJOR_MASK) != MAJOR_BSTR)
                    begin
                        err_next   = ST_NOT_BSTR;
                        phase_next = PH_ERR;
                    end
                    else if (info < INFO_LEN8)
                    begin
                        pay_len_next = info;
                        phase_next   = (info == 8'd0) ? PH_TRAIL : PH_PREFIX;
                    end
                    else if (info == INFO_LEN8)
                        phase_next = PH_LEN;
                    else
                    begin
                        err_next   = ST_LEN_FORM;
                        phase_next = PH_ERR;
                    end
                end
                PH_LEN:
                begin
                    pay_len_next = link_byte;
                    phase_next   = (link_byte == 8'd0) ? PH_TRAIL : PH_PREFIX;
                end
                PH_PREFIX:
                begin
                    pay_seen_next = 8'd1;
                    if (link_byte != PREFIX_IDENTITY)
                        err_next = ST_PREFIX;
                    phase_next = (pay_len_reg > 8'd1) ? PH_CID : PH_TRAIL;
                end
                PH_CID:
                begin
                    pay_seen_next = pay_seen_reg + 8'd1;
                    emit          = 1'b1;
                    if (pay_seen_next >= pay_len_reg)
                        phase_next = PH_TRAIL;
                end
                PH_TRAIL, PH_ERR:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // final status, from the state after this byte
    assign cid_len = pay_len_next - 8'd1;

    always_comb
    begin
        priority if (count_next < MIN_LINK_BYTES)
            fin_status = ST_SHORT;
        else if (err_next == ST_TAG0 || err_next == ST_TAG1 ||
                 err_next == ST_NOT_BSTR || err_next == ST_LEN_FORM)
            fin_status = err_next;
        else if (pay_seen_next < pay_len_next)
            fin_status = ST_TRUNCATED;
        else if (pay_len_next == 8'd0)
            fin_status = ST_CID_LEN;
        else if (err_next == ST_PREFIX)
            fin_status = ST_PREFIX;
        else if (cid_len == 8'd0 || cid_len > CID_LEN_MAX)
            fin_status = ST_CID_LEN;
        else if (capacity_reg < cid_len)
            fin_status = ST_CAPACITY;
        else
            fin_status = ST_OK;
    end

    always_comb
    begin
        res.cid_byte_valid = emit;
        res.cid_byte       = emit ? link_byte : 8'd0;
        res.done_res       = is_last;
        res.status         = is_last ? fin_status : ST_OK;
        res.cid_length     = (is_last && fin_status == ST_OK) ? cid_len[6:0] : 7'd0;
    end

    assign push = in_xfer && (emit || is_last);

    // parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            phase_reg    <= PH_TAG0;
            count_reg    <= '0;
            pay_len_reg  <= 8'd0;
            pay_seen_reg <= 8'd0;
            err_reg      <= ST_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            if (in_xfer)
            begin
                if (is_last)
                begin
                    // link ends: drop all per-link state
                    phase_reg    <= PH_TAG0;
                    count_reg    <= '0;
                    pay_len_reg  <= 8'd0;
                    pay_seen_reg <= 8'd0;
                    err_reg      <= ST_OK;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    count_reg    <= count_next;
                    pay_len_reg  <= pay_len_next;
                    pay_seen_reg <= pay_seen_next;
                    err_reg      <= err_next;
                end
            end
        end
    end

    // output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (!head_valid_reg)
                head_valid_reg <= push;
            else if (out_xfer)
            begin
                head_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
                skid_valid_reg <= 1'b1;
        end
    end

    // output queue payload
    always_ff @(posedge clk)
    begin
        priority if (!head_valid_reg || (out_xfer && !skid_valid_reg))
        begin
            if (push)
                head_reg <= res;
        end
        else if (out_xfer)
            head_reg <= skid_reg;
        else if (push)
            skid_reg <= res;
    end

endmodule : cbor_tag42_link_parser_core
`default_nettype wire

@@ tb/sv/tb_cbor_tag42_link_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cbor_tag42_link_parser_core
// Feeds encoded tag-42 links byte by byte: directed header and length cases,
// then random links, some of them corrupted, mixed with noise. A local decoder
// predicts every CID byte and final status. Both channels stall at random.
// The capacity register is rewritten between phases, from 0 up to 255.
// ----------------------------------------------------------------------------
module tb_cbor_tag42_link_parser_core;
    import cbor42_pkg::*;

    localparam int unsigned LINK_BYTE_LIMIT = 255;
    localparam int unsigned SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } link_item_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_TAG0,
        FLAW_TAG1,
        FLAW_MAJOR,
        FLAW_INFO,
        FLAW_PREFIX,
        FLAW_TRUNC,
        FLAW_SHORT
    } link_flaw_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] link_byte      = 8'd0;
    logic       is_last        = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic       cid_byte_valid;
    logic [7:0] cid_byte;
    logic       done_res;
    status_t    status;
    logic [6:0] cid_length;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data       = 8'd0;

    cbor_tag42_link_parser_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .link_byte      (link_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cid_byte_valid (cid_byte_valid),
        .cid_byte       (cid_byte),
        .done_res       (done_res),
        .status         (status),
        .cid_length     (cid_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    link_item_t  pending_bytes[$];
    result_t     expected_results[$];
    int unsigned queued_bytes;
    int unsigned mismatches;

    // idle behavior: 0 keeps the side busy, 1 inserts random gaps
    int unsigned send_idle_mode;
    int unsigned recv_idle_mode;
    int unsigned send_gap;
    int unsigned recv_gap;
    logic        hold_request = 1'b0;
    logic        hold_taken   = 1'b0;
    int unsigned hold_left;

    // decoder state mirrored on the testbench side
    phase_t      link_phase;
    logic [7:0]  link_count;
    logic [7:0]  bstr_length;
    logic [7:0]  bstr_seen;
    status_t     link_error;
    logic [7:0]  cap_shadow;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap(input int unsigned mode);
        int unsigned roll;
        if (mode == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic clear_link_state();
        link_phase  = PH_TAG0;
        link_count  = 8'd0;
        bstr_length = 8'd0;
        bstr_seen   = 8'd0;
        link_error  = ST_OK;
    endtask

    task automatic open_payload(input logic [7:0] n);
        bstr_length = n;
        if (n == 8'd0)
            link_phase = PH_TRAIL;
        else
            link_phase = PH_PREFIX;
    endtask

    // Advance the local decoder by one byte and queue the result it yields.
    task automatic decode_link_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic       emit;
        logic [7:0] info;
        logic [7:0] cid_len;
        r    = '0;
        emit = 1'b0;
        if (link_count < LINK_BYTE_LIMIT)
        begin
            link_count++;
            case (link_phase)
                PH_TAG0:
                    if (b != TAG0_BYTE)
                    begin
                        link_error = ST_TAG0;
                        link_phase = PH_ERR;
                    end
                    else
                        link_phase = PH_TAG1;
                PH_TAG1:
                    if (b != TAG1_BYTE)
                    begin
                        link_error = ST_TAG1;
                        link_phase = PH_ERR;
                    end
                    else
                        link_phase = PH_HDR;
                PH_HDR:
                begin
                    info = b & INFO_MASK;
                    if ((b & MAJOR_MASK) != MAJOR_BSTR)
                    begin
                        link_error = ST_NOT_BSTR;
                        link_phase = PH_ERR;
                    end
                    else if (info < INFO_LEN8)
                        open_payload(info);
                    else if (info == INFO_LEN8)
                        link_phase = PH_LEN;
                    else
                    begin
                        link_error = ST_LEN_FORM;
                        link_phase = PH_ERR;
                    end
                end
                PH_LEN:
                    open_payload(b);
                PH_PREFIX:
                begin
                    bstr_seen = 8'd1;
                    if (b != PREFIX_IDENTITY)
                        link_error = ST_PREFIX;
                    if (bstr_seen < bstr_length)
                        link_phase = PH_CID;
                    else
                        link_phase = PH_TRAIL;
                end
                PH_CID:
                begin
                    bstr_seen++;
                    emit = 1'b1;
                    if (bstr_seen >= bstr_length)
                        link_phase = PH_TRAIL;
                end
                default:
                    ;
            endcase
        end

        if (last)
        begin
            r.done_res = 1'b1;
            cid_len    = bstr_length - 8'd1;
            if (link_count < MIN_LINK_BYTES)
                r.status = ST_SHORT;
            else if (link_error >= ST_TAG0 && link_error <= ST_LEN_FORM)
                r.status = link_error;
            else if (bstr_seen < bstr_length)
                r.status = ST_TRUNCATED;
            else if (bstr_length == 8'd0)
                r.status = ST_CID_LEN;
            else if (link_error == ST_PREFIX)
                r.status = ST_PREFIX;
            else if (cid_len == 8'd0 || cid_len > CID_LEN_MAX)
                r.status = ST_CID_LEN;
            else if (cap_shadow < cid_len)
                r.status = ST_CAPACITY;
            else
            begin
                r.status     = ST_OK;
                r.cid_length = cid_len[6:0];
            end
        end

        if (emit)
        begin
            r.cid_byte_valid = 1'b1;
            r.cid_byte       = b;
        end
        if (emit || last)
            expected_results.push_back(r);
        if (last)
            clear_link_state();
    endtask

    // Input driver: hold each byte until its transfer, then gap or advance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                decode_link_byte(link_byte, is_last);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    link_byte <= pending_bytes[0].data;
                    is_last   <= pending_bytes[0].last;
                    void'(pending_bytes.pop_front());
                    send_gap = pick_gap(send_idle_mode);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check every transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: extra result, expected none, actual %0d/%02h %0d %0d %0d",
                             $time, cid_byte_valid, cid_byte, done_res, status, cid_length);
                    mismatches++;
                end
                else
                begin
                    check_field("cid_byte_valid", expected_results[0].cid_byte_valid,
                                cid_byte_valid);
                    check_field("cid_byte", expected_results[0].cid_byte, cid_byte);
                    check_field("done_res", expected_results[0].done_res, done_res);
                    check_field("status", expected_results[0].status, status);
                    check_field("cid_length", expected_results[0].cid_length, cid_length);
                    void'(expected_results.pop_front());
                end
            end
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap = pick_gap(recv_idle_mode);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        link_item_t item;
        item.data = b;
        item.last = last;
        pending_bytes.push_back(item);
        queued_bytes++;
    endtask

    // Queue up to eight bytes given most significant first; the final one ends the link.
    task automatic queue_raw(input int n, input logic [63:0] bytes);
        for (int i = 0; i < n; i++)
            push_byte(bytes[8 * (n - 1 - i) +: 8], i == n - 1);
    endtask

    task automatic queue_link(input int plen, input bit long_hdr, input link_flaw_t flaw,
                              input int trail);
        logic [7:0] enc[$];
        int         prefix_at;
        int         keep;
        int         major;
        enc.push_back(TAG0_BYTE);
        enc.push_back(TAG1_BYTE);
        if (long_hdr || plen > 23)
        begin
            enc.push_back(MAJOR_BSTR | INFO_LEN8);
            enc.push_back(8'(plen));
        end
        else
            enc.push_back(MAJOR_BSTR | 8'(plen));
        prefix_at = enc.size();
        if (plen > 0)
            enc.push_back(PREFIX_IDENTITY);
        for (int i = 1; i < plen; i++)
            enc.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < trail; i++)
            enc.push_back(8'($urandom_range(0, 255)));

        case (flaw)
            FLAW_TAG0:
                enc[0] = enc[0] ^ 8'(1 << $urandom_range(0, 7));
            FLAW_TAG1:
                enc[1] = enc[1] ^ 8'(1 << $urandom_range(0, 7));
            FLAW_MAJOR:
            begin
                // any major type but byte string
                major = $urandom_range(0, 6);
                if (major >= 2)
                    major++;
                enc[2] = {3'(major), enc[2][4:0]};
            end
            FLAW_INFO:
                enc[2] = MAJOR_BSTR | 8'($urandom_range(25, 31));
            FLAW_PREFIX:
                if (plen > 0)
                    enc[prefix_at] = 8'($urandom_range(1, 255));
            FLAW_TRUNC:
                if (enc.size() > 5)
                begin
                    keep = $urandom_range(4, enc.size() - 1);
                    while (enc.size() > keep)
                        void'(enc.pop_back());
                end
            FLAW_SHORT:
            begin
                keep = $urandom_range(1, 3);
                while (enc.size() > keep)
                    void'(enc.pop_back());
            end
            default:
                ;
        endcase

        for (int i = 0; i < enc.size(); i++)
            push_byte(enc[i], i == enc.size() - 1);
    endtask

    // Mostly well-formed links of small size, some corrupted, some pure noise.
    task automatic queue_random_links(input int unsigned n_bytes);
        int unsigned stop_at;
        int          roll;
        int          plen;
        int          n;
        link_flaw_t  flaw;
        stop_at = queued_bytes + n_bytes;
        while (queued_bytes < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)),
                              i == n - 1 || $urandom_range(0, 3) == 0);
            end
            else
            begin
                if (roll < 70)
                    flaw = FLAW_NONE;
                else
                    flaw = link_flaw_t'($urandom_range(FLAW_TAG0, FLAW_SHORT));
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    plen = $urandom_range(1, 23);
                else if (roll < 90)
                    plen = $urandom_range(24, 110);
                else if (roll < 96)
                    plen = 0;
                else
                    plen = $urandom_range(200, 255);
                queue_link(plen, $urandom_range(0, 3) == 0, flaw,
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            end
        end
    endtask

    // Wait until every byte is taken and every result has come back.
    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_shadow = value;
    endtask

    initial
    begin
        queued_bytes   = 0;
        mismatches     = 0;
        send_idle_mode = 1;
        recv_idle_mode = 1;
        send_gap       = 0;
        recv_gap       = 0;
        hold_left      = 0;
        cap_shadow     = CAPACITY_RESET;
        clear_link_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // long-form header with a one-byte CID of 0x80: ok
        queue_raw(6, 64'hD8_2A_58_02_00_80);
        // lone byte: short link
        queue_raw(1, 64'hFF);
        // wrong first tag byte
        queue_raw(4, 64'h00_2A_42_00);
        // wrong second tag byte
        queue_raw(4, 64'hD8_00_41_00);
        // major type is not a byte string
        queue_raw(4, 64'hD8_2A_60_00);
        // reserved length info
        queue_raw(4, 64'hD8_2A_5F_00);
        // payload cut short
        queue_raw(5, 64'hD8_2A_43_00_AA);
        // empty byte string, trailing byte ignored
        queue_raw(4, 64'hD8_2A_40_EE);
        drain();

        write_capacity(8'd255);
        queue_random_links(250);
        drain();

        // no idling on either side
        send_idle_mode = 0;
        recv_idle_mode = 0;
        write_capacity(8'd0);
        queue_random_links(200);
        drain();

        send_idle_mode = 1;
        recv_idle_mode = 1;
        write_capacity(8'($urandom_range(1, 99)));
        queue_random_links(250);
        drain();

        // stall the receiver for a long stretch while bytes keep coming
        send_idle_mode = 0;
        write_capacity(CAPACITY_RESET);
        @(negedge clk);
        hold_request = 1'b1;
        queue_random_links(300);
        drain();

        if (mismatches == 0)
            $display("tb_cbor_tag42_link_parser_core: clean");
        else
            $display("tb_cbor_tag42_link_parser_core: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_cbor_tag42_link_parser_core: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cbor42_pkg.sv
hdl/cbor_tag42_link_parser_core.sv
tb/sv/tb_cbor_tag42_link_parser_core.sv
